@@ hdl/lfbp_pkg.sv @@
// Package for the LSB-first field bit packer: command and status codes,
// the job record passed from the front end to the back end, and sizes.
// No dependencies.
`timescale 1ns / 1ps

package lfbp_pkg;

    localparam int unsigned LFBP_MAX_RAW_BITS = 56;
    localparam int unsigned LFBP_JOB_BITS     = 73;
    localparam int unsigned LFBP_LEN_BITS     = 7;
    localparam int unsigned LFBP_ACC_BITS     = 80;
    localparam int unsigned LFBP_QUEUE_DEPTH  = 2;

    localparam int unsigned U64_SMALL_LIMIT = 17;
    localparam int unsigned U64_MID_LIMIT   = 273;

    typedef enum logic [2:0] {
        CMD_RAW   = 3'd0,
        CMD_BOOL  = 3'd1,
        CMD_U32   = 3'd2,
        CMD_U64   = 3'd3,
        CMD_FLUSH = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_WIDTH = 2'd2
    } status_t;

    typedef struct packed {
        logic [LFBP_JOB_BITS-1:0] bits;
        logic [LFBP_LEN_BITS-1:0] len;
        status_t                  status;
        logic                     flush;
    } job_t;

endpackage

@@ hdl/lfbp_front.sv @@
// Front end of the bit packer: decodes one command item into a job with
// its bit string, length and error status. Depends on lfbp_pkg.
`timescale 1ns / 1ps

module lfbp_front #(
    parameter int unsigned MAX_RAW_BITS = lfbp_pkg::LFBP_MAX_RAW_BITS
) (
    input  logic              in_valid,
    input  logic [2:0]        command,
    input  logic [63:0]       value,
    input  logic [5:0]        bit_count,
    input  logic [3:0][31:0]  offsets,
    input  logic [3:0][5:0]   extra_bits,
    output logic              job_valid,
    output lfbp_pkg::job_t    job
);
    import lfbp_pkg::*;

    logic [31:0]              diff [4];
    logic [3:0]               fits;
    logic [1:0]               sel;
    logic [5:0]               sel_eb;
    logic [31:0]              sel_rem;
    logic [LFBP_LEN_BITS-1:0] u32_len;
    logic [63:0]              raw_mask;
    logic [LFBP_JOB_BITS-1:0] u64_bits;
    logic [LFBP_LEN_BITS-1:0] u64_len;
    logic [5:0]               grp_flag;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            diff[i] = value[31:0] - offsets[i];
            fits[i] = (diff[i] >> extra_bits[i]) == 32'd0;
        end
        sel     = 2'd0;
        sel_eb  = extra_bits[0];
        sel_rem = diff[0];
        for (int i = 3; i >= 0; i--) begin
            if (fits[i]) begin
                sel     = 2'(i);
                sel_eb  = extra_bits[i];
                sel_rem = diff[i];
            end
        end
        u32_len = {1'b0, sel_eb} + 7'd2;
    end

    // Long U64 form: a 14-bit head, then 9-bit groups of flag and byte, and a
    // final flag at bit 68, then value[63:60]. Bits past the end are already zero.
    always_comb begin
        u64_bits        = '0;
        u64_bits[13:0]  = {value[11:0], 2'b11};
        for (int k = 0; k < 6; k++) begin
            grp_flag[k]             = |(value >> (12 + 8 * k));
            u64_bits[14 + 9 * k]    = grp_flag[k];
            u64_bits[15 + 9 * k +: 8] = value[12 + 8 * k +: 8];
        end
        u64_bits[68]    = |value[63:60];
        u64_bits[72:69] = value[63:60];
        u64_len = (|value[63:60]) ? 7'd73 : 7'd69;
        for (int k = 5; k >= 0; k--) begin
            if (!grp_flag[k]) begin
                u64_len = 7'(15 + 9 * k);
            end
        end
    end

    assign raw_mask = ~({64{1'b1}} << bit_count);

    always_comb begin
        job       = '0;
        job_valid = in_valid;
        unique case (cmd_t'(command))
            CMD_RAW: begin
                if ({1'b0, bit_count} > 7'(MAX_RAW_BITS)) begin
                    job.status = ST_WIDTH;
                end else begin
                    job.bits = LFBP_JOB_BITS'(value & raw_mask);
                    job.len  = {1'b0, bit_count};
                end
            end
            CMD_BOOL: begin
                job.bits = LFBP_JOB_BITS'(|value);
                job.len  = 7'd1;
            end
            CMD_U32: begin
                if (fits == 4'd0) begin
                    job.status = ST_NOFIT;
                end else if (u32_len > 7'(MAX_RAW_BITS)) begin
                    job.status = ST_WIDTH;
                end else begin
                    job.bits = LFBP_JOB_BITS'({sel_rem, sel});
                    job.len  = u32_len;
                end
            end
            CMD_U64: begin
                if (value == 64'd0) begin
                    job.len = 7'd2;
                end else if (value < 64'(U64_SMALL_LIMIT)) begin
                    job.bits = LFBP_JOB_BITS'({value[3:0] - 4'd1, 2'b01});
                    job.len  = 7'd6;
                end else if (value < 64'(U64_MID_LIMIT)) begin
                    job.bits = LFBP_JOB_BITS'({value[7:0] - 8'(U64_SMALL_LIMIT), 2'b10});
                    job.len  = 7'd10;
                end else begin
                    job.bits = u64_bits;
                    job.len  = u64_len;
                end
            end
            CMD_FLUSH: begin
                job.flush = 1'b1;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/lfbp_queue.sv @@
// Short job queue between the front end and the back end of the packer.
// Depends on lfbp_pkg.
`timescale 1ns / 1ps

module lfbp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lfbp_pkg::job_t push_job,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output lfbp_pkg::job_t head
);
    import lfbp_pkg::*;

    localparam int unsigned PTR_BITS = $clog2(LFBP_QUEUE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(LFBP_QUEUE_DEPTH + 1);

    job_t                mem_reg [LFBP_QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign ready   = count_reg != CNT_BITS'(LFBP_QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/lfbp_back.sv @@
// Back end of the packer: merges each job into the pending bit accumulator
// and sends out completed bytes or status items through an output register.
// Depends on lfbp_pkg.
`timescale 1ns / 1ps

module lfbp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  lfbp_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);
    import lfbp_pkg::*;

    logic [LFBP_ACC_BITS-1:0] acc_reg, acc_next;
    logic [LFBP_LEN_BITS-1:0] cnt_reg, cnt_next;
    status_t                  stat_reg, stat_next;
    logic                     valid_reg, valid_next;
    logic [7:0]               byte_reg, byte_next;
    logic [2:0]               user_reg, user_next;
    logic                     last_reg, last_next;
    logic                     can_load;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        stat_next  = stat_reg;
        valid_next = (valid_reg && m_tready) ? 1'b0 : valid_reg;
        byte_next  = byte_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (stat_reg != ST_OK) begin
            if (can_load) begin
                valid_next = 1'b1;
                byte_next  = 8'd0;
                user_next  = {stat_reg, 1'b0};
                last_next  = 1'b1;
                stat_next  = ST_OK;
            end
        end else if (cnt_reg >= 7'd8) begin
            if (can_load) begin
                valid_next = 1'b1;
                byte_next  = acc_reg[7:0];
                user_next  = {ST_OK, 1'b1};
                last_next  = cnt_reg < 7'd16;
                acc_next   = acc_reg >> 8;
                cnt_next   = cnt_reg - 7'd8;
            end
        end else if (q_valid) begin
            q_pop = 1'b1;
            if (q_job.status != ST_OK) begin
                stat_next = q_job.status;
            end else if (q_job.flush) begin
                cnt_next = (cnt_reg[2:0] != 3'd0) ? 7'd8 : 7'd0;
            end else begin
                acc_next = acc_reg | (LFBP_ACC_BITS'(q_job.bits) << cnt_reg[2:0]);
                cnt_next = cnt_reg + q_job.len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            stat_reg  <= ST_OK;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            stat_reg  <= stat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

@@ hdl/lsb_first_field_bit_packer_unit.sv @@
// Top level of the LSB-first field bit packer: front-end decoder, job queue
// and byte-emitting back end. Depends on lfbp_pkg, lfbp_front, lfbp_queue
// and lfbp_back.
//
//   Channel | Direction | tdata                          | tuser                | tlast
//   s_      | in        | value, bit_count, offsets, eb  | command              | -
//   m_      | out       | out_byte                       | byte_valid, status   | last_of_run
//
// An item is decoded in the cycle it is accepted and queued; the back end merges
// its bits into the accumulator and then sends its results, up to ten bytes per
// item, and takes no new item while a whole byte is pending. The back end's byte
// shifter sends one byte per cycle while the output is not stalled.
// Reset is synchronous and clears the pending bits; no clearing pass is needed.
// Either side may stall independently; the queue and output register hold items.
`timescale 1ns / 1ps

module lsb_first_field_bit_packer_unit #(
    parameter int unsigned MAX_RAW_BITS = lfbp_pkg::LFBP_MAX_RAW_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value[63:0], bit_count[69:64], offset_0..3[197:70], extra_bits_0..3[221:198]
    input  logic [223:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte[7:0]
    output logic [7:0]   m_tdata,
    // byte_valid[0], status[2:1]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import lfbp_pkg::*;

    logic [3:0][31:0] offsets;
    logic [3:0][5:0]  extra_bits;
    logic             job_valid;
    job_t             front_job;
    logic             q_valid;
    logic             q_pop;
    job_t             q_head;

    assign offsets    = s_tdata[197:70];
    assign extra_bits = s_tdata[221:198];

    lfbp_front #(
        .MAX_RAW_BITS(MAX_RAW_BITS)
    ) u_front (
        .in_valid  (s_tvalid),
        .command   (s_tuser),
        .value     (s_tdata[63:0]),
        .bit_count (s_tdata[69:64]),
        .offsets   (offsets),
        .extra_bits(extra_bits),
        .job_valid (job_valid),
        .job       (front_job)
    );

    lfbp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_valid),
        .push_job(front_job),
        .ready   (s_tready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    lfbp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

@@ hdl/lfbp_checker.sv @@
// Port-level checks for the bit packer's result channel, bound to the top
// level. Depends on lsb_first_field_bit_packer_unit.
`timescale 1ns / 1ps

module lfbp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("status item is not a lone last item");

    a_status_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == 2'd0)) && m_tuser[2:1] != 2'd3)
        else $error("byte item with error status or status item without error");

endmodule

bind lsb_first_field_bit_packer_unit lfbp_checker u_lfbp_checker (.*);
